// File: src/bba_pkg.sv
// Shared constants, codes and types of the bitmap block allocator.
package bba_pkg;

	localparam int NUM_BLOCKS        = 4096;
	localparam int FIRST_ALLOCATABLE = 3;
	localparam int WORD_W            = 32;
	localparam int MAP_WORDS         = NUM_BLOCKS / WORD_W;
	localparam int MAP_AW            = $clog2(MAP_WORDS);
	localparam int WCNT_W            = $clog2(MAP_WORDS + 1);
	localparam int BIT_W             = $clog2(WORD_W);
	localparam int FIRST_WORD        = FIRST_ALLOCATABLE / WORD_W;
	localparam int FIRST_BIT         = FIRST_ALLOCATABLE % WORD_W;
	localparam int BLK_W             = 12;
	localparam int WIDX_W            = 7;
	localparam int CNT_W             = 13;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

endpackage

// File: src/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/bitmap_block_allocator.sv
// Bitmap first-fit block allocator: one word of request in, one word of response out.
// The free-block bitmap (set bit = free) sits in a 128 x 32 RAM with registered read;
// a valid flop per RAM word makes every word read as all-used until it is loaded or
// written, so there is no clearing pass after reset. One request is worked at a time.
// Load writes its word on accept and then goes to the output state; free and query
// read the word first, then free modifies and writes it back while query samples the
// bit, then both go to the output state; a rejected free (block 0 or out of range) and
// an out-of-range query go straight to the output state. Allocate scans one bitmap word
// per cycle through the RAM read port, starting at word 0, until a word holds a free
// block or the words that the block count covers are done. A response held in the output
// register does not block acceptance of the next request.
module bitmap_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          total_blocks_we,
	input  logic [bba_pkg::CNT_W-1:0]     total_blocks,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bba_pkg::op_t                  opcode,
	input  logic [bba_pkg::BLK_W-1:0]     block_number,
	input  logic [bba_pkg::WIDX_W-1:0]    word_index,
	input  logic [bba_pkg::WORD_W-1:0]    word_value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bba_pkg::status_t              status,
	output logic [bba_pkg::BLK_W-1:0]     allocated_block,
	output logic                          is_free
);

	import bba_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_SCAN,
		S_OUT
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [BLK_W-1:0]       blk_q;
	logic [CNT_W-1:0]       total_blocks_q;
	logic [MAP_WORDS-1:0]   valid_q;
	logic [WCNT_W-1:0]      scan_q;
	logic [MAP_AW-1:0]      addr_s1;
	logic                   pend_s1;
	status_t                res_status_q;
	logic [BLK_W-1:0]       res_blk_q;
	logic                   res_free_q;
	logic                   rsp_valid_q;
	status_t                status_q;
	logic [BLK_W-1:0]       allocated_block_q;
	logic                   is_free_q;

	logic [CNT_W-1:0]       count;
	logic [WCNT_W-1:0]      nwords;
	logic [CNT_W-BIT_W-1:0] full_words;
	logic                   blk_in;
	logic                   free_ok;
	logic                   load_ok;
	logic                   scan_more;
	logic                   out_load;
	logic [WORD_W-1:0]      ram_rdata;
	logic [WORD_W-1:0]      rd_word;
	logic [WORD_W-1:0]      bit_sel;
	logic [WORD_W-1:0]      mask_lo;
	logic [WORD_W-1:0]      mask_hi;
	logic [WORD_W-1:0]      cand;
	logic                   hit;
	logic [BIT_W-1:0]       hit_idx;
	logic                   ram_we;
	logic [MAP_AW-1:0]      ram_waddr;
	logic [WORD_W-1:0]      ram_wdata;
	logic                   ram_re;
	logic [MAP_AW-1:0]      ram_raddr;

	assign count = (total_blocks_q > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : total_blocks_q;
	assign nwords = WCNT_W'(((CNT_W + 1)'(count) + (CNT_W + 1)'(WORD_W - 1)) >> BIT_W);
	assign full_words = count[CNT_W-1:BIT_W];
	assign blk_in = (CNT_W'(block_number) < count);
	assign free_ok = (block_number != '0) && blk_in;
	assign load_ok = (int'(word_index) < MAP_WORDS);
	assign scan_more = (scan_q < nwords);
	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	assign rd_word = valid_q[addr_s1] ? ram_rdata : '0;
	assign bit_sel = WORD_W'(1) << blk_q[BIT_W-1:0];

	always_comb begin
		if (int'(addr_s1) < FIRST_WORD) begin
			mask_lo = '0;
		end else if (int'(addr_s1) == FIRST_WORD) begin
			mask_lo = {WORD_W{1'b1}} << FIRST_BIT;
		end else begin
			mask_lo = '1;
		end
		if (CNT_W'(addr_s1) < CNT_W'(full_words)) begin
			mask_hi = '1;
		end else begin
			mask_hi = ~({WORD_W{1'b1}} << count[BIT_W-1:0]);
		end
		cand = rd_word & mask_lo & mask_hi;
		hit = pend_s1 && (cand != '0);
		hit_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				hit_idx = BIT_W'(i);
			end
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = MAP_AW'(block_number >> BIT_W);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (opcode == OP_LOAD && load_ok) begin
						ram_we = 1'b1;
						ram_waddr = MAP_AW'(word_index);
						ram_wdata = word_value;
					end
					if ((opcode == OP_FREE && free_ok) || (opcode == OP_QUERY && blk_in)) begin
						ram_re = 1'b1;
					end
				end
			end
			S_RD: begin
				if (op_q == OP_FREE) begin
					ram_we = 1'b1;
					ram_wdata = rd_word | bit_sel;
				end
			end
			S_SCAN: begin
				ram_re = scan_more;
				ram_raddr = MAP_AW'(scan_q);
				if (hit) begin
					ram_we = 1'b1;
					ram_wdata = rd_word & ~(WORD_W'(1) << hit_idx);
				end
			end
			default: begin
			end
		endcase
	end

	bba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_blocks_q <= '0;
			valid_q <= '0;
			pend_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (total_blocks_we) begin
				total_blocks_q <= total_blocks;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= opcode;
						blk_q <= block_number;
						addr_s1 <= MAP_AW'(block_number >> BIT_W);
						scan_q <= '0;
						pend_s1 <= 1'b0;
						res_status_q <= ST_OK;
						res_blk_q <= '0;
						res_free_q <= 1'b0;
						case (opcode)
							OP_ALLOC: begin
								state_q <= S_SCAN;
							end
							OP_FREE: begin
								if (free_ok) begin
									state_q <= S_RD;
								end else begin
									res_status_q <= ST_RANGE;
									state_q <= S_OUT;
								end
							end
							OP_QUERY: begin
								state_q <= blk_in ? S_RD : S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RD: begin
					if (op_q == OP_QUERY) begin
						res_free_q <= ((rd_word & bit_sel) != '0);
					end
					state_q <= S_OUT;
				end
				S_SCAN: begin
					pend_s1 <= scan_more;
					addr_s1 <= MAP_AW'(scan_q);
					if (scan_more) begin
						scan_q <= scan_q + WCNT_W'(1);
					end
					if (hit) begin
						res_blk_q <= BLK_W'({addr_s1, hit_idx});
						state_q <= S_OUT;
					end else if (!pend_s1 && !scan_more) begin
						res_status_q <= ST_NOFREE;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						status_q <= res_status_q;
						allocated_block_q <= res_blk_q;
						is_free_q <= res_free_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign allocated_block = allocated_block_q;
	assign is_free = is_free_q;

endmodule

// File: test/bitmap_block_allocator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap block allocator: directed and random requests against an internal bitmap predictor.
module bitmap_block_allocator_test;
	import bba_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_200_000;

	typedef struct {
		status_t              status;
		logic [BLK_W-1:0]     block;
		logic                 free_bit;
	} alloc_rsp_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	class free_map_scoreboard;
		logic [WORD_W-1:0] free_map [MAP_WORDS];
		int unsigned       block_count;
		alloc_rsp_t        owed_q [$];
		int                errors;
		int                requests;
		int                grants;
		int                misses;
		int                rejects;
		int                free_hits;

		function new();
			foreach (free_map[i]) free_map[i] = '0;
			block_count = 0;
			errors      = 0;
			requests    = 0;
			grants      = 0;
			misses      = 0;
			rejects     = 0;
			free_hits   = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] value);
			block_count = (value > NUM_BLOCKS) ? NUM_BLOCKS : value;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void accept_request(op_t op, logic [BLK_W-1:0] blk,
				logic [WIDX_W-1:0] widx, logic [WORD_W-1:0] wval);
			alloc_rsp_t rsp;
			int         b;
			rsp.status   = ST_OK;
			rsp.block    = '0;
			rsp.free_bit = 1'b0;
			requests++;
			case (op)
				OP_ALLOC: begin
					rsp.status = ST_NOFREE;
					for (b = FIRST_ALLOCATABLE; b < block_count; b++) begin
						if (free_map[b / WORD_W][b % WORD_W]) begin
							free_map[b / WORD_W][b % WORD_W] = 1'b0;
							rsp.status = ST_OK;
							rsp.block  = BLK_W'(b);
							break;
						end
					end
					if (rsp.status == ST_OK) grants++;
					else misses++;
				end
				OP_FREE: begin
					if (blk == 0 || blk >= block_count) begin
						rsp.status = ST_RANGE;
						rejects++;
					end else begin
						free_map[blk / WORD_W][blk % WORD_W] = 1'b1;
					end
				end
				OP_QUERY: begin
					rsp.free_bit = (blk < block_count) && free_map[blk / WORD_W][blk % WORD_W];
					if (rsp.free_bit) free_hits++;
				end
				default: begin
					if (widx < MAP_WORDS) free_map[widx] = wval;
				end
			endcase
			owed_q.push_back(rsp);
		endfunction

		function void check_response(status_t st, logic [BLK_W-1:0] blk, logic fb);
			alloc_rsp_t want;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: response with no request outstanding (status %0d, block %0d, free %0b)",
					$time, st, blk, fb);
				return;
			end
			want = owed_q.pop_front();
			if (st !== want.status) begin
				errors++;
				$display("%0t: status expected %0d, actual %0d", $time, want.status, st);
			end
			if (blk !== want.block) begin
				errors++;
				$display("%0t: allocated_block expected %0d, actual %0d", $time, want.block, blk);
			end
			if (fb !== want.free_bit) begin
				errors++;
				$display("%0t: is_free expected %0b, actual %0b", $time, want.free_bit, fb);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                total_blocks_we;
	logic [CNT_W-1:0]    total_blocks;
	logic                req_valid;
	logic                req_stall;
	op_t                 opcode;
	logic [BLK_W-1:0]    block_number;
	logic [WIDX_W-1:0]   word_index;
	logic [WORD_W-1:0]   word_value;
	logic                rsp_valid;
	logic                rsp_stall;
	status_t             status;
	logic [BLK_W-1:0]    allocated_block;
	logic                is_free;

	free_map_scoreboard  sb = new();
	int unsigned         cycles = 0;
	int                  burst_left = 0;
	int                  settings = 0;

	bitmap_block_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.total_blocks_we (total_blocks_we),
		.total_blocks    (total_blocks),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.opcode          (opcode),
		.block_number    (block_number),
		.word_index      (word_index),
		.word_value      (word_value),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.allocated_block (allocated_block),
		.is_free         (is_free)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** bitmap_block_allocator: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_response(status, allocated_block, is_free);
	end

	initial begin
		stall_mode_t mode;
		int unsigned tick;
		tick      = 0;
		rsp_stall = 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				case (mode)
					STALL_NONE:  rsp_stall = 1'b0;
					STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
					STALL_HEAVY: rsp_stall = 1'($urandom_range(0, 1));
					default:     rsp_stall = (tick % 7) < 3;
				endcase
				tick++;
			end
		end
	end

	task automatic issue(op_t op, logic [BLK_W-1:0] blk, logic [WIDX_W-1:0] widx,
			logic [WORD_W-1:0] wval);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid    = 1'b1;
		opcode       = op;
		block_number = blk;
		word_index   = widx;
		word_value   = wval;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.accept_request(op, blk, widx, wval);
	endtask

	task automatic set_count(logic [CNT_W-1:0] value);
		@(negedge clk);
		req_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
		total_blocks_we = 1'b1;
		total_blocks    = value;
		@(negedge clk);
		total_blocks_we = 1'b0;
		sb.set_count(value);
		settings++;
	endtask

	task automatic random_request();
		op_t               op;
		logic [BLK_W-1:0]  blk;
		logic [WIDX_W-1:0] widx;
		logic [WORD_W-1:0] wval;
		int unsigned       lim;
		int unsigned       pick;
		lim  = sb.block_count;
		pick = $urandom_range(0, 99);
		if (pick < 35) op = OP_ALLOC;
		else if (pick < 60) op = OP_FREE;
		else if (pick < 80) op = OP_QUERY;
		else op = OP_LOAD;
		if (lim > 0 && $urandom_range(0, 4) != 0) blk = BLK_W'($urandom_range(0, lim - 1));
		else blk = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
		if (lim > 0 && $urandom_range(0, 4) != 0) widx = WIDX_W'($urandom_range(0, (lim - 1) / WORD_W));
		else widx = WIDX_W'($urandom_range(0, MAP_WORDS - 1));
		case ($urandom_range(0, 4))
			0:       wval = '0;
			1:       wval = '1;
			2:       wval = 32'd1 << $urandom_range(0, WORD_W - 1);
			3:       wval = $urandom & $urandom & $urandom;
			default: wval = $urandom;
		endcase
		issue(op, blk, widx, wval);
	endtask

	initial begin
		logic [CNT_W-1:0] plan [12];
		int               p;
		arst_n          = 1'b0;
		total_blocks_we = 1'b0;
		total_blocks    = '0;
		req_valid       = 1'b0;
		opcode          = OP_ALLOC;
		block_number    = '0;
		word_index      = '0;
		word_value      = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// no file system loaded
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_QUERY, 5, 0, 0);
		issue(OP_FREE, 5, 0, 0);
		issue(OP_LOAD, 0, 0, 32'hFFFF_FFFF);
		issue(OP_QUERY, 5, 0, 0);

		set_count(13'd4096);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_QUERY, 2, 0, 0);
		issue(OP_FREE, 0, 0, 0);
		issue(OP_FREE, 4095, 0, 0);
		issue(OP_FREE, 4095, 0, 0);
		issue(OP_QUERY, 4095, 0, 0);
		// only reserved blocks free in word 0
		issue(OP_LOAD, 0, 0, 32'h0000_0007);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_LOAD, 0, 127, 32'hFFFF_FFFF);
		issue(OP_LOAD, 0, 64, 32'h0000_0001);
		issue(OP_ALLOC, 0, 0, 0);

		set_count(13'd8191);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_QUERY, 4095, 0, 0);

		set_count(13'd40);
		issue(OP_QUERY, 4095, 0, 0);
		issue(OP_FREE, 40, 0, 0);
		issue(OP_FREE, 39, 0, 0);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_LOAD, 0, 1, 32'hFFFF_FFFF);
		issue(OP_ALLOC, 0, 0, 0);

		plan = '{13'd4096, 13'd8191, 13'd0, 13'd1, 13'd3, 13'd4,
			13'd32, 13'd33, 13'd100, 13'd0, 13'd0, 13'd4096};
		plan[9]  = CNT_W'($urandom_range(5, NUM_BLOCKS - 1));
		plan[10] = CNT_W'($urandom_range(NUM_BLOCKS + 1, 8190));
		for (p = 0; p < 12; p++) begin
			set_count(plan[p]);
			repeat ((plan[p] < 8) ? 40 : 170) random_request();
		end

		@(negedge clk);
		req_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (150) @(posedge clk);

		$display("Covered %0d requests over %0d block-count settings: %0d grants, %0d full misses,",
			sb.requests, settings, sb.grants, sb.misses);
		$display("%0d rejected frees, %0d free query answers, %0d mismatches.",
			sb.rejects, sb.free_hits, sb.errors);
		if (sb.errors == 0) begin
			$display("** bitmap_block_allocator: PASSED **");
		end else begin
			$display("** bitmap_block_allocator: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/bba_pkg.sv
src/bba_ram.sv
src/bitmap_block_allocator.sv
test/bitmap_block_allocator_test.sv
